### src/ptcta_pkg.sv
// Shared widths, request codes and memory word layouts for the per-task CPU time accounting block.
package ptcta_pkg;

    localparam int TASK_SLOTS = 1024;
    localparam int SLOT_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;

    localparam int KIND_W = 2;
    localparam int TASK_W = 10;
    localparam int STAMP_W = 64;
    localparam int CPU_W = 8;

    localparam int S_TDATA_W = 96;
    localparam int M_TDATA_W = 152;
    localparam int M_TUSER_W = 2;

    localparam logic [KIND_W-1:0] REQ_SWITCH = 2'd0;
    localparam logic [KIND_W-1:0] REQ_SAMPLE = 2'd1;
    localparam logic [KIND_W-1:0] REQ_EXIT = 2'd2;

    typedef struct packed {
        logic               valid;
        logic [STAMP_W-1:0] stamp;
    } start_word_t;

    typedef struct packed {
        logic               present;
        logic [CPU_W-1:0]   cpu;
        logic [STAMP_W-1:0] stamp;
        logic [STAMP_W-1:0] total;
    } record_word_t;

endpackage

### src/per_task_cpu_time_accounting_top.sv
// Top level of the per-task CPU time accounting block: slot tables, charge logic and stream ports.
//
//  Channel | Dir | tdata (low bit up)                               | tuser
//  s_      | in  | first_task, second_task, now_stamp, cpu_id       | req_type
//  m_      | out | task_out, total_time, last_stamp, last_cpu       | record_valid, charged
//
// A request passes through acceptance with the table reads, the elapsed-time
// subtraction, then the run-total addition with the table write-back and result register.
// The tables are single-write memories with registered reads. After reset a clearing
// pass writes every slot of both tables, during which no request is accepted. A request may be
// accepted while a result still waits; the write-back stage holds while the result
// register is full and not taken.
module per_task_cpu_time_accounting_top
    import ptcta_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // first_task[9:0], second_task[19:10], now_stamp[83:20], cpu_id[91:84], zero fill
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // req_type[1:0]
    input  logic [KIND_W-1:0]     s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // task_out[9:0], total_time[73:10], last_stamp[137:74], last_cpu[145:138], zero fill
    output logic [M_TDATA_W-1:0]  m_tdata,
    // record_valid[0], charged[1]
    output logic [M_TUSER_W-1:0]  m_tuser
);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DELTA,
        ST_SUM
    } state_t;

    state_t state_reg;
    logic [SLOT_W-1:0] clr_cnt_reg;

    logic [KIND_W-1:0]  kind_reg;
    logic [TASK_W-1:0]  t1_reg;
    logic [TASK_W-1:0]  t2_reg;
    logic [STAMP_W-1:0] now_reg;
    logic [CPU_W-1:0]   cpu_reg;
    logic [STAMP_W-1:0] delta_reg;

    start_word_t  start_mem [TASK_SLOTS];
    record_word_t record_mem [TASK_SLOTS];
    start_word_t  start_rd_reg;
    record_word_t record_rd_reg;

    logic                  m_tvalid_reg;
    logic [TASK_W-1:0]     m_task_reg;
    logic                  m_valid_reg;
    logic                  m_charged_reg;
    logic [STAMP_W-1:0]    m_total_reg;
    logic [STAMP_W-1:0]    m_stamp_reg;
    logic [CPU_W-1:0]      m_cpu_reg;

    logic [TASK_W-1:0] in_t1;
    logic              accept;
    logic              ok1;
    logic              ok2;
    logic              do_charge;
    logic              advance;
    logic [STAMP_W-1:0] total_next;
    logic              start_we;
    logic [SLOT_W-1:0] start_wa;
    start_word_t       start_wd;
    logic              record_we;
    logic [SLOT_W-1:0] record_wa;
    record_word_t      record_wd;

    assign in_t1 = s_tdata[TASK_W-1:0];
    assign s_tready = (state_reg == ST_IDLE);
    assign accept = s_tvalid && s_tready;

    assign ok1 = (32'(t1_reg) < TASK_SLOTS);
    assign ok2 = (32'(t2_reg) < TASK_SLOTS);

    always_comb begin
        do_charge = 1'b0;
        if (ok1 && start_rd_reg.valid) begin
            if (kind_reg == REQ_SWITCH) begin
                do_charge = 1'b1;
            end else if (kind_reg == REQ_SAMPLE) begin
                do_charge = record_rd_reg.present;
            end
        end
    end

    assign total_next = record_rd_reg.present ? (record_rd_reg.total + delta_reg) : delta_reg;
    assign advance = (state_reg == ST_SUM) && (!m_tvalid_reg || m_tready);

    always_comb begin
        start_we = 1'b0;
        start_wa = SLOT_W'(t1_reg);
        start_wd = '0;
        record_we = 1'b0;
        record_wa = SLOT_W'(t1_reg);
        record_wd = '0;
        if (state_reg == ST_CLEAR) begin
            start_we = 1'b1;
            start_wa = clr_cnt_reg;
            record_we = 1'b1;
            record_wa = clr_cnt_reg;
        end else if (advance) begin
            if (do_charge) begin
                record_we = 1'b1;
                record_wd = '{present: 1'b1, cpu: cpu_reg, stamp: now_reg, total: total_next};
            end
            if (kind_reg == REQ_SWITCH) begin
                start_we = ok2;
                start_wa = SLOT_W'(t2_reg);
                start_wd = '{valid: 1'b1, stamp: now_reg};
            end else if (kind_reg == REQ_SAMPLE) begin
                start_we = do_charge;
                start_wd = '{valid: 1'b1, stamp: now_reg};
            end else if (kind_reg == REQ_EXIT) begin
                start_we = ok1;
                record_we = ok1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start_we) begin
            start_mem[start_wa] <= start_wd;
        end
        if (accept) begin
            start_rd_reg <= start_mem[SLOT_W'(in_t1)];
        end
    end

    always_ff @(posedge aclk) begin
        if (record_we) begin
            record_mem[record_wa] <= record_wd;
        end
        if (accept) begin
            record_rd_reg <= record_mem[SLOT_W'(in_t1)];
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            kind_reg <= s_tuser;
            t1_reg <= in_t1;
            t2_reg <= s_tdata[2*TASK_W-1:TASK_W];
            now_reg <= s_tdata[2*TASK_W+STAMP_W-1:2*TASK_W];
            cpu_reg <= s_tdata[2*TASK_W+STAMP_W+CPU_W-1:2*TASK_W+STAMP_W];
        end
        if (state_reg == ST_DELTA) begin
            delta_reg <= now_reg - start_rd_reg.stamp;
        end
        if (advance) begin
            m_task_reg <= t1_reg;
            m_charged_reg <= do_charge;
            if (do_charge) begin
                m_valid_reg <= 1'b1;
                m_total_reg <= total_next;
                m_stamp_reg <= now_reg;
                m_cpu_reg <= cpu_reg;
            end else if (ok1 && record_rd_reg.present) begin
                m_valid_reg <= 1'b1;
                m_total_reg <= record_rd_reg.total;
                m_stamp_reg <= record_rd_reg.stamp;
                m_cpu_reg <= record_rd_reg.cpu;
            end else begin
                m_valid_reg <= 1'b0;
                m_total_reg <= '0;
                m_stamp_reg <= '0;
                m_cpu_reg <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            clr_cnt_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_CLEAR: begin
                    clr_cnt_reg <= clr_cnt_reg + SLOT_W'(1);
                    if (clr_cnt_reg == SLOT_W'(TASK_SLOTS - 1)) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (accept) begin
                        state_reg <= ST_DELTA;
                    end
                end
                ST_DELTA: begin
                    state_reg <= ST_SUM;
                end
                ST_SUM: begin
                    if (advance) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_CLEAR;
                end
            endcase
            if (advance) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata = M_TDATA_W'({m_cpu_reg, m_stamp_reg, m_total_reg, m_task_reg});
    assign m_tuser = {m_charged_reg, m_valid_reg};

endmodule
